### rtl/firlp_pkg.sv
// shared constants, coefficient table and types of the low-pass fir filter
`timescale 1ns / 1ps

package firlp_pkg;

	localparam int TAPS         = 51;
	localparam int SAMPLE_WIDTH = 16;
	localparam int COEFF_WIDTH  = 18;
	localparam int ACC_WIDTH    = 40;
	localparam int FRAC         = COEFF_WIDTH - 1;
	localparam int ROM_LEN      = 51;
	localparam int PROD_WIDTH   = SAMPLE_WIDTH + COEFF_WIDTH;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic signed [COEFF_WIDTH-1:0]  coeff_t;
	typedef logic signed [ACC_WIDTH-1:0]    acc_t;
	typedef logic signed [PROD_WIDTH-1:0]   prod_t;

	localparam acc_t ROUND_HALF = acc_t'(64'sd1 <<< (FRAC - 1));
	localparam acc_t SAT_MAX    = acc_t'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
	localparam acc_t SAT_MIN    = acc_t'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

	// low-pass coefficients, signed q0.17
	localparam int COEF_ROM [ROM_LEN] = '{
		  22,  379,  297,  423,  560,  720,  903, 1109, 1336, 1584,
		1849, 2129, 2421, 2719, 3020, 3319, 3610, 3889, 4149, 4387,
		4597, 4775, 4918, 5022, 5085, 5106, 5085, 5022, 4918, 4775,
		4597, 4387, 4149, 3889, 3610, 3319, 3020, 2719, 2421, 2129,
		1849, 1584, 1336, 1109,  903,  720,  560,  423,  297,  379,
		  22
	};

	// taps past the end of the table get a zero coefficient
	function automatic coeff_t coef_at(input int k);
		coeff_t c;
		c = '0;
		if (k < ROM_LEN) begin
			c = coeff_t'(COEF_ROM[k]);
		end
		return c;
	endfunction

endpackage

### rtl/firlp_in_if.sv
// input sample channel of the low-pass fir filter
`timescale 1ns / 1ps

interface firlp_in_if;
	logic                 valid;
	logic                 ready;
	firlp_pkg::sample_t   sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

### rtl/firlp_out_if.sv
// filtered result channel of the low-pass fir filter
`timescale 1ns / 1ps

interface firlp_out_if;
	logic                 valid;
	logic                 ready;
	firlp_pkg::sample_t   filtered_out;

	modport source (output valid, output filtered_out, input ready);
	modport sink   (input valid, input filtered_out, output ready);
endinterface

### rtl/firlp_tap_cell.sv
// one cell of the transposed fir chain: multiply-add into a partial sum register
`timescale 1ns / 1ps

module firlp_tap_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  firlp_pkg::sample_t  sample,
	input  firlp_pkg::coeff_t   coef,
	input  firlp_pkg::acc_t     psum_in,
	output firlp_pkg::acc_t     psum_out
);

	firlp_pkg::prod_t prod;
	firlp_pkg::acc_t  psum_q;

	assign prod = sample * coef;

	// sum wraps modulo the accumulator width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psum_q <= '0;
		end else if (en) begin
			psum_q <= psum_in + firlp_pkg::acc_t'(prod);
		end
	end

	assign psum_out = psum_q;

endmodule

### rtl/firlp_round_sat.sv
// round-half-up by the coefficient fraction and saturate to sample width
`timescale 1ns / 1ps

module firlp_round_sat (
	input  firlp_pkg::acc_t     acc,
	output firlp_pkg::sample_t  result
);

	firlp_pkg::acc_t rounded;
	firlp_pkg::acc_t shifted;

	assign rounded = acc + firlp_pkg::ROUND_HALF;
	assign shifted = rounded >>> firlp_pkg::FRAC;

	always_comb begin
		if (shifted > firlp_pkg::SAT_MAX) begin
			result = firlp_pkg::sample_t'(firlp_pkg::SAT_MAX);
		end else if (shifted < firlp_pkg::SAT_MIN) begin
			result = firlp_pkg::sample_t'(firlp_pkg::SAT_MIN);
		end else begin
			result = firlp_pkg::sample_t'(shifted);
		end
	end

endmodule

### rtl/fir_lowpass_51_tap.sv
// top level of the 51-tap low-pass fir filter
`timescale 1ns / 1ps

// Low-pass FIR with 51 fixed Q0.17 coefficients, one filtered word per sample word.
// Built as a transposed chain of multiply-add cells that all advance on each
// accepted sample, so a new sample is taken every clock while the output side
// keeps up. A sample's sum sits in the first cell in the cycle after acceptance, and
// its rounded, saturated result is loaded into the output register once that is
// free. Throughput is one word per cycle; it drops only when the output register
// is stalled by the downstream side, since the chain holds its state until the
// pending sum has moved on. Reset clears the chain, which matches an all-zero
// delay line.

module fir_lowpass_51_tap (
	input  logic               clk,
	input  logic               arst_n,
	firlp_in_if.sink           din,
	firlp_out_if.source        dout
);

	firlp_pkg::acc_t    psum [firlp_pkg::TAPS];
	firlp_pkg::sample_t rs_result;
	logic               accept;
	logic               out_free;
	logic               sum_valid_q;
	logic               out_valid_q;
	firlp_pkg::sample_t out_data_q;

	assign out_free  = !out_valid_q || dout.ready;
	assign din.ready = !sum_valid_q || out_free;
	assign accept    = din.valid && din.ready;

	for (genvar k = 0; k < firlp_pkg::TAPS; k++) begin : g_cell
		firlp_pkg::acc_t psum_next;
		if (k == firlp_pkg::TAPS - 1) begin : g_last
			assign psum_next = '0;
		end else begin : g_mid
			assign psum_next = psum[k+1];
		end
		firlp_tap_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (accept),
			.sample   (din.sample_in),
			.coef     (firlp_pkg::coef_at(k)),
			.psum_in  (psum_next),
			.psum_out (psum[k])
		);
	end

	// first cell holds the complete sum of the newest sample
	firlp_round_sat u_round_sat (
		.acc    (psum[0]),
		.result (rs_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				sum_valid_q <= 1'b1;
			end else if (sum_valid_q && out_free) begin
				sum_valid_q <= 1'b0;
			end
			if (sum_valid_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid_q && out_free) begin
			out_data_q <= rs_result;
		end
	end

	assign dout.valid        = out_valid_q;
	assign dout.filtered_out = out_data_q;

	// a new sum never overwrites one that has not moved to the output
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!sum_valid_q || out_free))
		else $error("pending sum overwritten");

	a_sum_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> sum_valid_q)
		else $error("sum not marked valid after accept");

	a_sum_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_valid_q && out_free) |=> dout.valid)
		else $error("finished sum did not reach output");

	a_out_needs_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dout.valid) |-> $past(sum_valid_q))
		else $error("output valid without a pending sum");

endmodule
